// ----- rtl/pjec_pkg.sv -----
// Package for the joint effort PID controller.
// Holds widths, register indexes, sequencer codes and the joint state record.
// No dependencies.
package pjec_pkg;

	localparam int NumJoints  = 32;
	localparam int JointW     = 5;
	localparam int AddrW      = $clog2(NumJoints);
	localparam int DataW      = 32;
	localparam int DtW        = 24;

	localparam logic [2:0] RegGainPosP = 3'd0;
	localparam logic [2:0] RegGainPosI = 3'd1;
	localparam logic [2:0] RegGainPosD = 3'd2;
	localparam logic [2:0] RegGainVelP = 3'd3;
	localparam logic [2:0] RegIntegMin = 3'd4;
	localparam logic [2:0] RegIntegMax = 3'd5;

	localparam logic FuncStep  = 1'b0;
	localparam logic FuncClear = 1'b1;

	typedef struct packed {
		logic signed [DataW-1:0] prev_err;
		logic signed [DataW-1:0] deriv;
		logic signed [DataW-1:0] integ;
	} joint_state_t;

	typedef struct packed {
		logic signed [DataW-1:0] gain_p;
		logic signed [DataW-1:0] gain_i;
		logic signed [DataW-1:0] gain_d;
		logic signed [DataW-1:0] gain_v;
		logic signed [DataW-1:0] integ_min;
		logic signed [DataW-1:0] integ_max;
	} cfg_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[DataW-1:0];
	endfunction

endpackage

// ----- rtl/pjec_state_ram.sv -----
// Per-joint state memory, one write and one registered read port.
// Uses pjec_pkg for the state record.
module pjec_state_ram (
	input  logic                         clk,
	input  logic [pjec_pkg::AddrW-1:0]   raddr,
	output pjec_pkg::joint_state_t       rdata,
	input  logic                         we,
	input  logic [pjec_pkg::AddrW-1:0]   waddr,
	input  pjec_pkg::joint_state_t       wdata
);
	import pjec_pkg::*;

	joint_state_t mem [NumJoints];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/pjec_divider.sv -----
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Uses pjec_pkg for widths.
module pjec_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic signed [57:0]          num,
	input  logic [pjec_pkg::DtW-1:0]    den,
	output logic                        done,
	output logic signed [58:0]          quot
);
	import pjec_pkg::*;

	logic [57:0] rem_q;
	logic [57:0] qbits_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        run_q;
	logic [DtW-1:0] den_q;
	logic [58:0] trial;
	logic [57:0] rem_sh;

	assign rem_sh = {rem_q[56:0], qbits_q[57]};
	assign trial  = {1'b0, rem_sh} - {35'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'd58;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q   <= num[57];
			qbits_q <= num[57] ? 58'(-num) : num;
			rem_q   <= '0;
			den_q   <= den;
		end else if (run_q) begin
			if (!trial[58]) begin
				rem_q   <= trial[57:0];
				qbits_q <= {qbits_q[56:0], 1'b1};
			end else begin
				rem_q   <= rem_sh;
				qbits_q <= {qbits_q[56:0], 1'b0};
			end
		end
	end

	assign quot = neg_q ? -$signed({1'b0, qbits_q}) : $signed({1'b0, qbits_q});
endmodule

// ----- rtl/pjec_datapath.sv -----
// Sequencer and shared 32x32 multiplier for one control step.
// Uses pjec_pkg, pjec_divider and the joint state read/write port.
module pjec_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  pjec_pkg::cfg_t                cfg,
	input  logic                          func,
	input  logic [pjec_pkg::JointW-1:0]   joint,
	input  logic signed [31:0]            target_position,
	input  logic signed [31:0]            measured_position,
	input  logic signed [31:0]            target_velocity,
	input  logic signed [31:0]            measured_velocity,
	input  logic signed [31:0]            feedforward_effort,
	input  logic signed [31:0]            low_stop,
	input  logic signed [31:0]            high_stop,
	input  logic [30:0]                   effort_limit,
	input  logic [pjec_pkg::DtW-1:0]      step_time,
	output logic [pjec_pkg::AddrW-1:0]    raddr,
	input  pjec_pkg::joint_state_t        rdata,
	output logic                          we,
	output logic [pjec_pkg::AddrW-1:0]    waddr,
	output pjec_pkg::joint_state_t        wdata,
	output logic                          result_valid,
	output logic [pjec_pkg::JointW-1:0]   joint_out,
	output logic signed [31:0]            effort,
	output logic                          saturated
);
	import pjec_pkg::*;

	localparam logic [3:0] StIdle  = 4'd0;
	localparam logic [3:0] StRead  = 4'd1;
	localparam logic [3:0] StErr   = 4'd2;
	localparam logic [3:0] StDiv   = 4'd3;
	localparam logic [3:0] StMulT  = 4'd4;
	localparam logic [3:0] StMulI  = 4'd5;
	localparam logic [3:0] StMulP  = 4'd6;
	localparam logic [3:0] StMulD  = 4'd7;
	localparam logic [3:0] StMulV  = 4'd8;
	localparam logic [3:0] StSum   = 4'd9;
	localparam logic [3:0] StOut   = 4'd10;

	logic [3:0] st_q;
	logic [AddrW-1:0] j_q;
	logic signed [31:0] tp_q, mp_q, tv_q, mv_q, ff_q, lo_q, hi_q;
	logic [30:0] lim_q;
	logic [DtW-1:0] dt_q;
	logic signed [31:0] err_q, verr_q, deriv_q, integ_q;
	logic signed [65:0] acc_q;
	logic signed [47:0] t_q;
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [47:0] prod_sh;
	logic signed [32:0] tgt;
	logic div_go, div_done;
	logic signed [58:0] quot;
	logic signed [57:0] dnum;
	logic signed [65:0] unc, clmp, lim_s, integ_n, integ_b;
	logic signed [65:0] imin, imax;

	assign busy = (st_q != StIdle);
	assign raddr = j_q;

	always_comb begin
		ma = cfg.gain_p;
		mb = err_q;
		unique case (st_q)
			StMulT: begin ma = err_q; mb = 32'(signed'({8'd0, dt_q})); end
			StMulI: begin ma = cfg.gain_i; mb = t_q[31:0]; end
			StMulD: begin ma = cfg.gain_d; mb = deriv_q; end
			StMulV: begin ma = cfg.gain_v; mb = verr_q; end
			default: ;
		endcase
	end

	assign prod    = 64'(ma) * 64'(mb);
	assign prod_sh = 48'(prod >>> 16);
	// previous error comes straight from the memory read data in the error step
	assign dnum    = 58'((66'(err_q) - 66'(rdata.prev_err)) <<< 24);

	assign imin  = 66'(cfg.integ_min);
	assign imax  = 66'(cfg.integ_max);
	assign lim_s = 66'(signed'({1'b0, lim_q}));
	assign unc   = acc_q + 66'(ff_q);
	always_comb begin
		clmp = unc;
		if (clmp > lim_s) clmp = lim_s;
		if (clmp < -lim_s) clmp = -lim_s;
		integ_b = 66'(integ_q) + (clmp - unc);
		if (integ_b > imax) integ_b = imax;
		if (integ_b < imin) integ_b = imin;
		integ_n = 66'(rdata.integ) + 66'(prod_sh);
		if (integ_n > imax) integ_n = imax;
		if (integ_n < imin) integ_n = imin;
		tgt = 33'(tp_q);
		if (tgt > 33'(hi_q)) tgt = 33'(hi_q);
		if (tgt < 33'(lo_q)) tgt = 33'(lo_q);
	end

	assign div_go = (st_q == StErr) && (dt_q != '0);

	pjec_divider u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(dnum), .den(dt_q),
		.done(div_done), .quot(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			we <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			we <= 1'b0;
			result_valid <= 1'b0;
			unique case (st_q)
				StIdle: if (start && func == FuncClear) begin
					we <= 1'b1;
				end else if (start) begin
					st_q <= StRead;
				end
				StRead: st_q <= StErr;
				StErr:  st_q <= (dt_q != '0) ? StDiv : StMulT;
				StDiv:  if (div_done) st_q <= StMulT;
				StMulT: st_q <= StMulI;
				StMulI: st_q <= StMulP;
				StMulP: st_q <= StMulD;
				StMulD: st_q <= StMulV;
				StMulV: st_q <= StSum;
				StSum:  st_q <= StOut;
				StOut: begin
					st_q <= StIdle;
					we <= 1'b1;
					result_valid <= 1'b1;
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			StIdle: if (start) begin
				j_q <= joint; tp_q <= target_position; mp_q <= measured_position;
				tv_q <= target_velocity; mv_q <= measured_velocity;
				ff_q <= feedforward_effort; lo_q <= low_stop; hi_q <= high_stop;
				lim_q <= effort_limit; dt_q <= step_time;
				waddr <= joint; wdata <= '0;
			end
			StRead: begin
				err_q  <= sat32(66'(tgt) - 66'(mp_q));
				verr_q <= sat32(66'(tv_q) - 66'(mv_q));
			end
			StErr: begin
				deriv_q <= rdata.deriv;
			end
			StDiv: if (div_done) deriv_q <= sat32(66'(quot));
			StMulT: t_q <= 48'(prod >>> 24);
			StMulI: integ_q <= integ_n[31:0];
			StMulP: acc_q <= 66'(prod_sh) + 66'(integ_q);
			StMulD: acc_q <= acc_q + 66'(prod_sh);
			StMulV: acc_q <= acc_q + 66'(prod_sh);
			StSum: begin
				effort <= clmp[31:0];
				saturated <= (clmp != unc);
				joint_out <= j_q;
				if ((clmp != unc) && (cfg.gain_i != '0)) integ_q <= integ_b[31:0];
			end
			StOut: wdata <= '{prev_err: err_q, deriv: deriv_q, integ: integ_q};
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) result_valid |-> we)
		else $error("result without state write-back");
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> st_q == StDiv)
		else $error("divider finished outside divide step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || we))
		else $error("accepted item dropped");
endmodule

// ----- rtl/pid_joint_effort_controller_top.sv -----
// Joint effort PID controller, top level: APB registers, state memory, sequencer.
// A step runs the divide step only when step_time is nonzero;
// a clear writes at the next edge, gives no result and leaves busy low. One item at a time.
// Reset clears the configuration registers and control; the joint state memory
// is swept to zero after reset, during which busy stays high.
// Results are strobed for one cycle; the receiver cannot stall.
module pid_joint_effort_controller_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [4:0]         joint,
	input  logic signed [31:0] target_position,
	input  logic signed [31:0] measured_position,
	input  logic signed [31:0] target_velocity,
	input  logic signed [31:0] measured_velocity,
	input  logic signed [31:0] feedforward_effort,
	input  logic signed [31:0] low_stop,
	input  logic signed [31:0] high_stop,
	input  logic [30:0]        effort_limit,
	input  logic [23:0]        step_time,
	output logic               result_valid,
	output logic [4:0]         joint_out,
	output logic signed [31:0] effort,
	output logic               saturated
);
	import pjec_pkg::*;

	cfg_t cfg_q;
	logic [2:0] ridx;
	logic dp_busy, dp_we;
	logic [AddrW-1:0] dp_waddr, raddr, m_waddr;
	joint_state_t dp_wdata, rdata, m_wdata;
	logic [AddrW:0] clr_q;
	logic clearing, m_we;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];

	// Register writes on the APB access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				RegGainPosP: cfg_q.gain_p <= pwdata;
				RegGainPosI: cfg_q.gain_i <= pwdata;
				RegGainPosD: cfg_q.gain_d <= pwdata;
				RegGainVelP: cfg_q.gain_v <= pwdata;
				RegIntegMin: cfg_q.integ_min <= pwdata;
				RegIntegMax: cfg_q.integ_max <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			RegGainPosP: prdata = cfg_q.gain_p;
			RegGainPosI: prdata = cfg_q.gain_i;
			RegGainPosD: prdata = cfg_q.gain_d;
			RegGainVelP: prdata = cfg_q.gain_v;
			RegIntegMin: prdata = cfg_q.integ_min;
			RegIntegMax: prdata = cfg_q.integ_max;
			default:     prdata = '0;
		endcase
	end

	// Sweep the state memory to zero after reset.
	assign clearing = !clr_q[AddrW];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (clearing) clr_q <= clr_q + 1'b1;
	end

	assign m_we    = clearing || dp_we;
	assign m_waddr = clearing ? clr_q[AddrW-1:0] : dp_waddr;
	assign m_wdata = clearing ? '0 : dp_wdata;
	assign busy    = clearing || dp_busy;

	pjec_state_ram u_ram (
		.clk(clk), .raddr(raddr), .rdata(rdata),
		.we(m_we), .waddr(m_waddr), .wdata(m_wdata)
	);

	pjec_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .start(start && !clearing), .busy(dp_busy),
		.cfg(cfg_q), .func(func), .joint(joint),
		.target_position(target_position), .measured_position(measured_position),
		.target_velocity(target_velocity), .measured_velocity(measured_velocity),
		.feedforward_effort(feedforward_effort), .low_stop(low_stop),
		.high_stop(high_stop), .effort_limit(effort_limit), .step_time(step_time),
		.raddr(raddr), .rdata(rdata), .we(dp_we), .waddr(dp_waddr), .wdata(dp_wdata),
		.result_valid(result_valid), .joint_out(joint_out), .effort(effort),
		.saturated(saturated)
	);

	assert property (@(posedge clk) disable iff (!arst_n) clearing |-> !result_valid)
		else $error("result during memory sweep");
	assert property (@(posedge clk) disable iff (!arst_n) result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");
	assert property (@(posedge clk) disable iff (!arst_n) clearing |-> busy)
		else $error("ready during memory sweep");
endmodule
